// ===== design/ehs_pkg.sv =====
package ehs_pkg;

  // Axis count and the mask that keeps a start's axis bits in range
  localparam int NUM_AXES = 3;
  localparam logic [2:0] AXES_MASK = 3'((1 << NUM_AXES) - 1);

  // Stream widths, padded to whole bytes, and the move field width
  localparam int IN_TDATA_W  = 88;
  localparam int OUT_TDATA_W = 112;
  localparam int MOVE_W      = 27;

  // Configuration register indexes
  localparam logic [2:0] REG_ENABLED        = 3'd0;
  localparam logic [2:0] REG_MIN_INSTALLED  = 3'd1;
  localparam logic [2:0] REG_MAX_INSTALLED  = 3'd2;
  localparam logic [2:0] REG_INVERT         = 3'd3;
  localparam logic [2:0] REG_THRESHOLD      = 3'd4;
  localparam logic [2:0] REG_APPROACH_STEPS = 3'd5;
  localparam logic [2:0] REG_BACK_OFF_STEPS = 3'd6;
  localparam logic [2:0] REG_SLOW_DELAY     = 3'd7;

  // Configuration reset values
  localparam logic [9:0]  THRESHOLD_RST      = 10'd100;
  localparam logic [23:0] APPROACH_STEPS_RST = 24'd100000;
  localparam logic [23:0] BACK_OFF_STEPS_RST = 24'd5000;
  localparam logic [15:0] SLOW_DELAY_RST     = 16'd4000;

  // Request kinds carried in tuser
  localparam logic OP_TICK  = 1'b0;
  localparam logic OP_START = 1'b1;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_INITIAL,
    PH_AWAY,
    PH_FINAL
  } phase_t;

  typedef struct packed {
    logic        enabled;
    logic        min_installed;
    logic        max_installed;
    logic        invert;
    logic [9:0]  threshold;
    logic [23:0] approach_steps;
    logic [23:0] back_off_steps;
    logic [15:0] slow_delay;
  } cfg_t;

  typedef struct packed {
    phase_t      phase;
    logic [2:0]  latched_axes;
    logic        latched_dir;
    logic [15:0] saved_delay;
  } state_t;

  typedef struct packed {
    logic              op;
    logic [2:0]        home_axes;
    logic signed [1:0] home_dir;
    logic              in_motion;
    logic [5:0]        move_dirs;
    logic [15:0]       current_delay;
    logic [9:0]        min_sample_x;
    logic [9:0]        min_sample_y;
    logic [9:0]        min_sample_z;
    logic [9:0]        max_sample_x;
    logic [9:0]        max_sample_y;
    logic [9:0]        max_sample_z;
  } in_item_t;

  typedef struct packed {
    logic                     move_start;
    logic signed [MOVE_W-1:0] move_x;
    logic signed [MOVE_W-1:0] move_y;
    logic signed [MOVE_W-1:0] move_z;
    logic                     set_delay;
    logic [15:0]              new_delay;
    logic signed [2:0]        break_code;
    logic                     abort_hit;
    logic signed [1:0]        status_x;
    logic signed [1:0]        status_y;
    logic signed [1:0]        status_z;
    logic                     homing_done;
  } out_item_t;

endpackage

// ===== design/endstop_homing_sequencer_unit.sv =====
// Three-axis endstop monitor and homing sequencer. Each request is either a
// start (tuser = 1) that, if that side's stops are installed, latches an axis
// mask and direction and issues the long approach move, or a tick (tuser = 0)
// that carries the stop samples, move directions, moving flag and current step
// delay; every request gives exactly one result with per-axis switch status, the
// break code of the last axis driving into a hit stop, an abort flag, and, as
// each homing move ends, the retreat, the slow double-length approach, and the
// delay restore with a final retreat. One request is taken per cycle while the
// output does not stall; a result passes from the input register to the result
// register and is held there while the output stalls, and the sequencer phase is
// updated as a request moves into the result register.
// Configuration writes are taken at any time and belong while idle.
module endstop_homing_sequencer_unit (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // home_axes, home_dir, in_motion, move_dirs, current_delay,
  // min_sample_x, min_sample_y, min_sample_z, max_sample_x, max_sample_y, max_sample_z
  input  logic [ehs_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
  // op
  input  logic [0:0]                       s_axis_tuser,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // move_start, move_x, move_y, move_z, set_delay, new_delay, break_code,
  // abort_hit, status_x, status_y, status_z, homing_done, zero pad
  output logic [ehs_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [2:0]                       cfg_index,
  input  logic [23:0]                      cfg_data
);

  ehs_pkg::cfg_t      cfg;
  ehs_pkg::state_t    st;
  ehs_pkg::state_t    st_next;
  ehs_pkg::in_item_t  in_item;
  ehs_pkg::in_item_t  item_in;
  ehs_pkg::out_item_t res;
  logic               in_valid;
  logic               advance;
  logic               s_fire;

  assign cfg_ready = 1'b1;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.enabled        <= 1'b1;
      cfg.min_installed  <= 1'b1;
      cfg.max_installed  <= 1'b1;
      cfg.invert         <= 1'b0;
      cfg.threshold      <= ehs_pkg::THRESHOLD_RST;
      cfg.approach_steps <= ehs_pkg::APPROACH_STEPS_RST;
      cfg.back_off_steps <= ehs_pkg::BACK_OFF_STEPS_RST;
      cfg.slow_delay     <= ehs_pkg::SLOW_DELAY_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        ehs_pkg::REG_ENABLED:        cfg.enabled        <= cfg_data[0];
        ehs_pkg::REG_MIN_INSTALLED:  cfg.min_installed  <= cfg_data[0];
        ehs_pkg::REG_MAX_INSTALLED:  cfg.max_installed  <= cfg_data[0];
        ehs_pkg::REG_INVERT:         cfg.invert         <= cfg_data[0];
        ehs_pkg::REG_THRESHOLD:      cfg.threshold      <= cfg_data[9:0];
        ehs_pkg::REG_APPROACH_STEPS: cfg.approach_steps <= cfg_data;
        ehs_pkg::REG_BACK_OFF_STEPS: cfg.back_off_steps <= cfg_data;
        ehs_pkg::REG_SLOW_DELAY:     cfg.slow_delay     <= cfg_data[15:0];
        default: cfg.enabled <= cfg.enabled;
      endcase
    end
  end

  // Unpack the incoming request
  always_comb begin
    item_in.op            = s_axis_tuser[0];
    item_in.home_axes     = s_axis_tdata[2:0];
    item_in.home_dir      = s_axis_tdata[4:3];
    item_in.in_motion     = s_axis_tdata[5];
    item_in.move_dirs     = s_axis_tdata[11:6];
    item_in.current_delay = s_axis_tdata[27:12];
    item_in.min_sample_x  = s_axis_tdata[37:28];
    item_in.min_sample_y  = s_axis_tdata[47:38];
    item_in.min_sample_z  = s_axis_tdata[57:48];
    item_in.max_sample_x  = s_axis_tdata[67:58];
    item_in.max_sample_y  = s_axis_tdata[77:68];
    item_in.max_sample_z  = s_axis_tdata[87:78];
  end

  // Advance when the result register is free or being drained
  assign advance       = in_valid && (!m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;
  assign s_fire        = s_axis_tvalid && s_axis_tready;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_fire) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_fire) begin
      in_item <= item_in;
    end
  end

  ehs_step u_step (
    .cfg     (cfg),
    .st      (st),
    .item    (in_item),
    .res     (res),
    .st_next (st_next)
  );

  // Sequencer state, updated as a request is retired
  always_ff @(posedge clk) begin
    if (rst) begin
      st.phase        <= ehs_pkg::PH_IDLE;
      st.latched_axes <= 3'b000;
      st.latched_dir  <= 1'b0;
      st.saved_delay  <= 16'd0;
    end else if (advance) begin
      st <= st_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (advance) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      m_axis_tdata <= {2'b00, res.homing_done, res.status_z, res.status_y, res.status_x,
                       res.abort_hit, res.break_code, res.new_delay, res.set_delay,
                       res.move_z, res.move_y, res.move_x, res.move_start};
    end
  end

endmodule

// ===== design/ehs_step.sv =====
module ehs_step (
  input  ehs_pkg::cfg_t      cfg,
  input  ehs_pkg::state_t    st,
  input  ehs_pkg::in_item_t  item,
  output ehs_pkg::out_item_t res,
  output ehs_pkg::state_t    st_next
);

  logic [9:0]                       min_s [3];
  logic [9:0]                       max_s [3];
  logic [2:0]                       trig_min;
  logic [2:0]                       trig_max;
  logic signed [1:0]                stat [3];
  logic signed [2:0]                brk;
  logic                             dmax;
  logic                             start_ok;
  logic                             seq_step;
  logic [2:0]                       move_axes;
  logic                             move_en;
  logic signed [ehs_pkg::MOVE_W-1:0] move_len;
  logic signed [ehs_pkg::MOVE_W-1:0] mv [3];
  logic signed [ehs_pkg::MOVE_W-1:0] appr;
  logic signed [ehs_pkg::MOVE_W-1:0] back;
  logic signed [ehs_pkg::MOVE_W-1:0] back2;

  // Switch is low when below threshold, flipped by invert
  function automatic logic sw_low(input logic [9:0] s, input logic [9:0] thr,
                                  input logic inv);
    sw_low = (s < thr) != inv;
  endfunction

  assign min_s[0] = item.min_sample_x;
  assign min_s[1] = item.min_sample_y;
  assign min_s[2] = item.min_sample_z;
  assign max_s[0] = item.max_sample_x;
  assign max_s[1] = item.max_sample_y;
  assign max_s[2] = item.max_sample_z;

  // Evaluate switches and per-axis status
  always_comb begin
    trig_min = '0;
    trig_max = '0;
    for (int i = 0; i < 3; i++) begin
      stat[i] = 2'sd0;
    end
    for (int i = 0; i < ehs_pkg::NUM_AXES; i++) begin
      trig_min[i] = cfg.min_installed && sw_low(min_s[i], cfg.threshold, cfg.invert);
      trig_max[i] = cfg.max_installed && sw_low(max_s[i], cfg.threshold, cfg.invert);
      if (trig_min[i]) begin
        stat[i] = -2'sd1;
      end else if (trig_max[i]) begin
        stat[i] = 2'sd1;
      end
    end
  end

  // Find the last axis driving into a hit stop
  always_comb begin
    logic [1:0]        d;
    logic signed [2:0] mag;
    brk = 3'sd0;
    for (int i = 0; i < ehs_pkg::NUM_AXES; i++) begin
      d   = item.move_dirs[2*i +: 2];
      mag = 3'(i + 1);
      if (d != 2'd0) begin
        if (d[1] && trig_min[i]) begin
          brk = -mag;
        end else if (!d[1] && trig_max[i]) begin
          brk = mag;
        end
      end
    end
  end

  assign dmax     = !item.home_dir[1];
  assign start_ok = dmax ? cfg.max_installed : cfg.min_installed;
  assign seq_step = (item.op == ehs_pkg::OP_TICK) && cfg.enabled &&
                    (st.phase != ehs_pkg::PH_IDLE) && !item.in_motion;

  assign appr  = {3'b000, cfg.approach_steps};
  assign back  = {3'b000, cfg.back_off_steps};
  assign back2 = {2'b00, cfg.back_off_steps, 1'b0};

  // Next state
  always_comb begin
    st_next = st;
    if (item.op == ehs_pkg::OP_START) begin
      if (start_ok) begin
        st_next.phase        = ehs_pkg::PH_INITIAL;
        st_next.latched_axes = item.home_axes & ehs_pkg::AXES_MASK;
        st_next.latched_dir  = dmax;
      end
    end else if (seq_step) begin
      case (st.phase)
        ehs_pkg::PH_INITIAL: st_next.phase = ehs_pkg::PH_AWAY;
        ehs_pkg::PH_AWAY: begin
          st_next.phase       = ehs_pkg::PH_FINAL;
          st_next.saved_delay = item.current_delay;
        end
        ehs_pkg::PH_FINAL: st_next.phase = ehs_pkg::PH_IDLE;
        default: st_next.phase = st.phase;
      endcase
    end
  end

  // Outputs: pick the move, delay write and flags
  always_comb begin
    res       = '0;
    move_en   = 1'b0;
    move_len  = '0;
    move_axes = st.latched_axes;
    res.status_x = stat[0];
    res.status_y = stat[1];
    res.status_z = stat[2];
    if (item.op == ehs_pkg::OP_START) begin
      if (start_ok) begin
        move_en   = 1'b1;
        move_axes = item.home_axes & ehs_pkg::AXES_MASK;
        move_len  = dmax ? appr : -appr;
      end
    end else if (cfg.enabled) begin
      res.break_code = brk;
      res.abort_hit  = (brk != 3'sd0) && item.in_motion;
      if (seq_step) begin
        case (st.phase)
          ehs_pkg::PH_INITIAL: begin
            move_en  = 1'b1;
            move_len = st.latched_dir ? -back : back;
          end
          ehs_pkg::PH_AWAY: begin
            move_en       = 1'b1;
            move_len      = st.latched_dir ? back2 : -back2;
            res.set_delay = 1'b1;
            res.new_delay = cfg.slow_delay;
          end
          ehs_pkg::PH_FINAL: begin
            move_en         = 1'b1;
            move_len        = st.latched_dir ? -back : back;
            res.set_delay   = 1'b1;
            res.new_delay   = st.saved_delay;
            res.homing_done = 1'b1;
          end
          default: move_en = 1'b0;
        endcase
      end
    end
    for (int i = 0; i < 3; i++) begin
      mv[i] = (move_en && move_axes[i]) ? move_len : '0;
    end
    res.move_start = move_en;
    res.move_x     = mv[0];
    res.move_y     = mv[1];
    res.move_z     = mv[2];
  end

endmodule

// ===== design/ehs_checker.sv =====
module ehs_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [ehs_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // Drop move fields when no move is requested
  a_move_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tdata[0] |-> m_axis_tdata[81:1] == 81'd0)
    else $error("move fields set without move_start");

  // Drop the delay value when no delay write is requested
  a_delay_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tdata[82] |-> m_axis_tdata[98:83] == 16'd0)
    else $error("new_delay set without set_delay");

  // Finish only with a delay restore and a last retreat
  a_done_move: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[109] |-> m_axis_tdata[0] && m_axis_tdata[82])
    else $error("homing_done without move and delay restore");

  // Abort only on a hit stop
  a_abort_brk: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[102] |-> m_axis_tdata[101:99] != 3'd0)
    else $error("abort_hit with zero break_code");

endmodule

bind endstop_homing_sequencer_unit ehs_checker u_ehs_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

// ===== test/tb_endstop_homing_sequencer_unit.sv =====
`timescale 1ns / 1ps

module tb_endstop_homing_sequencer_unit;

  localparam int QUIET_LIMIT = 1000;

  logic                            clk = 1'b0;
  logic                            rst = 1'b1;
  logic                            s_axis_tvalid = 1'b0;
  logic                            s_axis_tready;
  logic [ehs_pkg::IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic [0:0]                      s_axis_tuser = '0;
  logic                            m_axis_tvalid;
  logic                            m_axis_tready = 1'b0;
  logic [ehs_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
  logic                            cfg_valid = 1'b0;
  logic                            cfg_ready;
  logic [2:0]                      cfg_index = '0;
  logic [23:0]                     cfg_data = '0;

  // Directed stimulus row: request plus an optional hand-written result
  typedef struct packed {
    ehs_pkg::in_item_t  req;
    logic               fixed;
    ehs_pkg::out_item_t res;
  } plan_row_t;

  plan_row_t plan[$];
  ehs_pkg::out_item_t due_reports[$];

  // Shadow copy of the registers and the homing sequencer state
  ehs_pkg::cfg_t   shadow_cfg;
  ehs_pkg::phase_t seq_phase;
  logic [2:0]      seq_axes;
  logic            seq_dir_max;
  logic [15:0]     seq_saved_delay;

  int burst_left = 0;
  int sent_items = 0;
  int mismatches = 0;
  int report_no = 0;
  int quiet_cycles = 0;
  logic [9:0] stall_tick = '0;

  endstop_homing_sequencer_unit uut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Pack request fields, home_axes in the lowest bits
  function automatic logic [ehs_pkg::IN_TDATA_W-1:0] pack_request(ehs_pkg::in_item_t it);
    return {it.max_sample_z, it.max_sample_y, it.max_sample_x,
            it.min_sample_z, it.min_sample_y, it.min_sample_x,
            it.current_delay, it.move_dirs, it.in_motion, it.home_dir, it.home_axes};
  endfunction

  function automatic ehs_pkg::out_item_t unpack_report(logic [ehs_pkg::OUT_TDATA_W-1:0] d);
    ehs_pkg::out_item_t r;
    r.move_start  = d[0];
    r.move_x      = d[27:1];
    r.move_y      = d[54:28];
    r.move_z      = d[81:55];
    r.set_delay   = d[82];
    r.new_delay   = d[98:83];
    r.break_code  = d[101:99];
    r.abort_hit   = d[102];
    r.status_x    = d[104:103];
    r.status_y    = d[106:105];
    r.status_z    = d[108:107];
    r.homing_done = d[109];
    return r;
  endfunction

  // A stop counts as hit when (sample < threshold) differs from invert
  function automatic logic side_hit(ehs_pkg::in_item_t it, int axis, logic max_side);
    logic [9:0] s;
    if (max_side) begin
      if (!shadow_cfg.max_installed) return 1'b0;
      s = (axis == 0) ? it.max_sample_x : (axis == 1) ? it.max_sample_y : it.max_sample_z;
    end else begin
      if (!shadow_cfg.min_installed) return 1'b0;
      s = (axis == 0) ? it.min_sample_x : (axis == 1) ? it.min_sample_y : it.min_sample_z;
    end
    return (s < shadow_cfg.threshold) != shadow_cfg.invert;
  endfunction

  // Request a relative move of len on every latched axis
  function automatic ehs_pkg::out_item_t with_move(ehs_pkg::out_item_t o, int len);
    o.move_start = 1'b1;
    o.move_x = seq_axes[0] ? ehs_pkg::MOVE_W'(len) : '0;
    o.move_y = seq_axes[1] ? ehs_pkg::MOVE_W'(len) : '0;
    o.move_z = seq_axes[2] ? ehs_pkg::MOVE_W'(len) : '0;
    return o;
  endfunction

  function automatic ehs_pkg::out_item_t homing_step(ehs_pkg::in_item_t it);
    ehs_pkg::out_item_t o;
    logic [1:0]         st [ehs_pkg::NUM_AXES];
    logic [1:0]         code;
    logic               dmax;
    int                 brk;
    int                 sgn;
    o = '0;
    for (int a = 0; a < ehs_pkg::NUM_AXES; a++)
      st[a] = side_hit(it, a, 1'b0) ? 2'b11 : (side_hit(it, a, 1'b1) ? 2'b01 : 2'b00);
    o.status_x = st[0];
    o.status_y = st[1];
    o.status_z = st[2];

    // Start: latch mask and direction unless that side has no switches
    if (it.op == ehs_pkg::OP_START) begin
      dmax = !it.home_dir[1];
      if (dmax ? shadow_cfg.max_installed : shadow_cfg.min_installed) begin
        seq_axes    = it.home_axes & ehs_pkg::AXES_MASK;
        seq_dir_max = dmax;
        seq_phase   = ehs_pkg::PH_INITIAL;
        o = with_move(o, dmax ? int'(shadow_cfg.approach_steps)
                              : -int'(shadow_cfg.approach_steps));
      end
      return o;
    end
    if (!shadow_cfg.enabled) return o;

    // Keep the last axis that drives into a hit stop
    brk = 0;
    for (int a = 0; a < ehs_pkg::NUM_AXES; a++) begin
      code = it.move_dirs[2*a +: 2];
      if (code != 2'b00 && side_hit(it, a, !code[1]))
        brk = code[1] ? -(a + 1) : a + 1;
    end
    o.break_code = 3'(brk);
    o.abort_hit  = (brk != 0) && it.in_motion;
    if (seq_phase == ehs_pkg::PH_IDLE || it.in_motion) return o;

    // Advance the sequence once the stage has stopped
    sgn = seq_dir_max ? 1 : -1;
    case (seq_phase)
      ehs_pkg::PH_INITIAL: begin
        seq_phase = ehs_pkg::PH_AWAY;
        o = with_move(o, -sgn * int'(shadow_cfg.back_off_steps));
      end
      ehs_pkg::PH_AWAY: begin
        seq_phase = ehs_pkg::PH_FINAL;
        seq_saved_delay = it.current_delay;
        o.set_delay = 1'b1;
        o.new_delay = shadow_cfg.slow_delay;
        o = with_move(o, 2 * sgn * int'(shadow_cfg.back_off_steps));
      end
      default: begin
        seq_phase = ehs_pkg::PH_IDLE;
        o.set_delay = 1'b1;
        o.new_delay = seq_saved_delay;
        o = with_move(o, -sgn * int'(shadow_cfg.back_off_steps));
        o.homing_done = 1'b1;
      end
    endcase
    return o;
  endfunction

  function automatic ehs_pkg::in_item_t mk_req(logic op, logic [2:0] axes, logic [1:0] dir,
                                               logic moving, logic [5:0] dirs,
                                               logic [15:0] dly,
                                               logic [9:0] lo, logic [9:0] hi);
    ehs_pkg::in_item_t r;
    r.op = op;
    r.home_axes = axes;
    r.home_dir = dir;
    r.in_motion = moving;
    r.move_dirs = dirs;
    r.current_delay = dly;
    r.min_sample_x = lo;
    r.min_sample_y = lo;
    r.min_sample_z = lo;
    r.max_sample_x = hi;
    r.max_sample_y = hi;
    r.max_sample_z = hi;
    return r;
  endfunction

  // Hand-written result: same move on all axes, same status on all axes
  function automatic ehs_pkg::out_item_t mk_res(int mv, int brk, logic ab, int st);
    ehs_pkg::out_item_t o;
    o = '0;
    o.move_start = (mv != 0);
    o.move_x = ehs_pkg::MOVE_W'(mv);
    o.move_y = ehs_pkg::MOVE_W'(mv);
    o.move_z = ehs_pkg::MOVE_W'(mv);
    o.break_code = 3'(brk);
    o.abort_hit = ab;
    o.status_x = 2'(st);
    o.status_y = 2'(st);
    o.status_z = 2'(st);
    return o;
  endfunction

  function automatic void add_row(ehs_pkg::in_item_t r, logic fixed, ehs_pkg::out_item_t e);
    plan_row_t row;
    row.req = r;
    row.fixed = fixed;
    row.res = e;
    plan.push_back(row);
  endfunction

  // Favor samples right at the threshold edge
  function automatic logic [9:0] pick_sample();
    case ($urandom_range(0, 4))
      0: return 10'd0;
      1: return 10'h3FF;
      2: return shadow_cfg.threshold - 10'd1;
      3: return shadow_cfg.threshold;
      default: return 10'($urandom);
    endcase
  endfunction

  function automatic ehs_pkg::in_item_t rand_req(logic op, logic moving);
    ehs_pkg::in_item_t r;
    r.op = op;
    r.home_axes = 3'($urandom);
    r.home_dir = 2'($urandom);
    r.in_motion = moving;
    r.move_dirs = 6'($urandom);
    r.current_delay = 16'($urandom);
    r.min_sample_x = pick_sample();
    r.min_sample_y = pick_sample();
    r.min_sample_z = pick_sample();
    r.max_sample_x = pick_sample();
    r.max_sample_y = pick_sample();
    r.max_sample_z = pick_sample();
    return r;
  endfunction

  // Drive one request in bursts with random gaps, predict once taken
  task automatic send_request(input ehs_pkg::in_item_t it, input logic fixed,
                              input ehs_pkg::out_item_t want);
    int                 gap;
    ehs_pkg::out_item_t predicted;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 48);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= it.op;
    s_axis_tdata  <= pack_request(it);
    do @(posedge clk); while (!s_axis_tready);
    predicted = homing_step(it);
    due_reports.push_back(fixed ? want : predicted);
    sent_items++;
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [23:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic load_setting(input int ph);
    ehs_pkg::cfg_t c;
    c.enabled        = ($urandom_range(0, 3) != 0);
    c.min_installed  = 1'($urandom);
    c.max_installed  = 1'($urandom);
    c.invert         = 1'($urandom);
    c.threshold      = 10'($urandom);
    c.approach_steps = 24'($urandom);
    c.back_off_steps = 24'($urandom);
    c.slow_delay     = 16'($urandom);
    case (ph)
      0: c = '{1'b1, 1'b1, 1'b1, 1'b0, ehs_pkg::THRESHOLD_RST, ehs_pkg::APPROACH_STEPS_RST,
               ehs_pkg::BACK_OFF_STEPS_RST, ehs_pkg::SLOW_DELAY_RST};
      1: c = '{1'b1, 1'b1, 1'b1, 1'b1, 10'h3FF, 24'hFFFFFF, 24'hFFFFFF, 16'hFFFF};
      2: c = '{1'b1, 1'b1, 1'b1, 1'b0, 10'd0, 24'd0, 24'd0, 16'd0};
      3: begin
        c.enabled = 1'b1;
        c.min_installed = 1'b0;
        c.max_installed = 1'b1;
      end
      4: begin
        c.enabled = 1'b1;
        c.min_installed = 1'b1;
        c.max_installed = 1'b0;
      end
      5: begin
        c.enabled = 1'b0;
        c.min_installed = 1'b1;
        c.max_installed = 1'b1;
      end
      default: ;
    endcase
    write_reg(ehs_pkg::REG_ENABLED, 24'(c.enabled));
    write_reg(ehs_pkg::REG_MIN_INSTALLED, 24'(c.min_installed));
    write_reg(ehs_pkg::REG_MAX_INSTALLED, 24'(c.max_installed));
    write_reg(ehs_pkg::REG_INVERT, 24'(c.invert));
    write_reg(ehs_pkg::REG_THRESHOLD, 24'(c.threshold));
    write_reg(ehs_pkg::REG_APPROACH_STEPS, c.approach_steps);
    write_reg(ehs_pkg::REG_BACK_OFF_STEPS, c.back_off_steps);
    write_reg(ehs_pkg::REG_SLOW_DELAY, 24'(c.slow_delay));
    cfg_valid <= 1'b0;
    shadow_cfg = c;
  endtask

  // Mostly complete homing runs with random content, some cut short, some noise
  task automatic run_random(input int quota);
    int stop_at;
    int k;
    stop_at = sent_items + quota;
    while (sent_items < stop_at) begin
      if ($urandom_range(0, 9) < 8) begin
        send_request(rand_req(ehs_pkg::OP_START, 1'b0), 1'b0, '0);
        for (k = 0; k < 3; k++) begin
          if ($urandom_range(0, 15) != 0) begin
            repeat ($urandom_range(0, 3))
              send_request(rand_req(ehs_pkg::OP_TICK, 1'b1), 1'b0, '0);
            send_request(rand_req(ehs_pkg::OP_TICK, 1'b0), 1'b0, '0);
          end
        end
      end else begin
        repeat ($urandom_range(1, 4))
          send_request(rand_req(1'($urandom), 1'($urandom)), 1'b0, '0);
      end
    end
  endtask

  task automatic drain_reports();
    s_axis_tvalid <= 1'b0;
    while (due_reports.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic check_field(input string name, input logic [26:0] want,
                             input logic [26:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= 10)
        $display("report %0d: %s expected %0h got %0h", report_no, name, want, got);
    end
  endtask

  // Receiver stall pattern: free flow, coin flips, long stalls, light stalls
  always @(posedge clk) begin
    stall_tick <= stall_tick + 10'd1;
    case (stall_tick[9:8])
      2'd0: m_axis_tready <= 1'b1;
      2'd1: m_axis_tready <= 1'($urandom);
      2'd2: m_axis_tready <= (stall_tick[4:0] >= 5'd20);
      default: m_axis_tready <= ($urandom_range(0, 3) != 0);
    endcase
  end

  // Compare each accepted result with the oldest prediction
  always @(posedge clk) begin
    ehs_pkg::out_item_t got;
    ehs_pkg::out_item_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = unpack_report(m_axis_tdata);
      if (due_reports.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("report %0d: no request outstanding", report_no);
      end else begin
        want = due_reports.pop_front();
        check_field("move_start", 27'(want.move_start), 27'(got.move_start));
        check_field("move_x", want.move_x, got.move_x);
        check_field("move_y", want.move_y, got.move_y);
        check_field("move_z", want.move_z, got.move_z);
        check_field("set_delay", 27'(want.set_delay), 27'(got.set_delay));
        check_field("new_delay", 27'(want.new_delay), 27'(got.new_delay));
        check_field("break_code", 27'(want.break_code), 27'(got.break_code));
        check_field("abort_hit", 27'(want.abort_hit), 27'(got.abort_hit));
        check_field("status_x", 27'(want.status_x), 27'(got.status_x));
        check_field("status_y", 27'(want.status_y), 27'(got.status_y));
        check_field("status_z", 27'(want.status_z), 27'(got.status_z));
        check_field("homing_done", 27'(want.homing_done), 27'(got.homing_done));
      end
      report_no++;
    end
  end

  // Drop the run when no channel moves for too long
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    ehs_pkg::in_item_t r;
    shadow_cfg = '{1'b1, 1'b1, 1'b1, 1'b0, ehs_pkg::THRESHOLD_RST,
                   ehs_pkg::APPROACH_STEPS_RST, ehs_pkg::BACK_OFF_STEPS_RST,
                   ehs_pkg::SLOW_DELAY_RST};
    seq_phase = ehs_pkg::PH_IDLE;
    seq_axes = '0;
    seq_dir_max = 1'b0;
    seq_saved_delay = '0;

    // Directed rows at the reset settings
    add_row(mk_req(ehs_pkg::OP_TICK, 3'd0, 2'b00, 1'b0, 6'h00, 16'd0, 10'h3FF, 10'h3FF),
            1'b1, mk_res(0, 0, 1'b0, 0));
    add_row(mk_req(ehs_pkg::OP_TICK, 3'd0, 2'b00, 1'b1, 6'h3F, 16'd0, 10'd0, 10'd0),
            1'b1, mk_res(0, -3, 1'b1, -1));
    add_row(mk_req(ehs_pkg::OP_TICK, 3'd0, 2'b00, 1'b0, 6'h15, 16'd0, 10'h3FF, 10'd0),
            1'b1, mk_res(0, 3, 1'b0, 1));
    // direction code 2 reads as negative
    add_row(mk_req(ehs_pkg::OP_TICK, 3'd7, 2'b11, 1'b1, 6'h2A, 16'hFFFF, 10'd0, 10'd0),
            1'b0, '0);
    // samples one below and right at the threshold
    r = mk_req(ehs_pkg::OP_TICK, 3'd0, 2'b00, 1'b0, 6'h0F, 16'd0, 10'd0, 10'h3FF);
    r.min_sample_x = 10'd99;
    r.min_sample_y = 10'd100;
    add_row(r, 1'b0, '0);
    // full sequence toward the min stops
    add_row(mk_req(ehs_pkg::OP_START, 3'd7, 2'b11, 1'b0, 6'h00, 16'd0, 10'h3FF, 10'h3FF),
            1'b1, mk_res(-100000, 0, 1'b0, 0));
    add_row(mk_req(ehs_pkg::OP_TICK, 3'd0, 2'b00, 1'b1, 6'h3F, 16'd0, 10'h3FF, 10'h3FF),
            1'b0, '0);
    add_row(mk_req(ehs_pkg::OP_TICK, 3'd0, 2'b00, 1'b0, 6'h00, 16'hFFFF, 10'h3FF, 10'h3FF),
            1'b0, '0);
    add_row(mk_req(ehs_pkg::OP_TICK, 3'd0, 2'b00, 1'b0, 6'h00, 16'd1234, 10'h3FF, 10'h3FF),
            1'b0, '0);
    add_row(mk_req(ehs_pkg::OP_TICK, 3'd0, 2'b00, 1'b0, 6'h00, 16'd0, 10'h3FF, 10'h3FF),
            1'b0, '0);
    add_row(mk_req(ehs_pkg::OP_TICK, 3'd0, 2'b00, 1'b0, 6'h00, 16'd0, 10'h3FF, 10'h3FF),
            1'b0, '0);
    // empty axis mask, then restarts while homing
    add_row(mk_req(ehs_pkg::OP_START, 3'd0, 2'b00, 1'b0, 6'h00, 16'd0, 10'h3FF, 10'h3FF),
            1'b0, '0);
    add_row(mk_req(ehs_pkg::OP_TICK, 3'd0, 2'b00, 1'b0, 6'h00, 16'd5, 10'h3FF, 10'h3FF),
            1'b0, '0);
    add_row(mk_req(ehs_pkg::OP_START, 3'd5, 2'b01, 1'b0, 6'h00, 16'd0, 10'h3FF, 10'h3FF),
            1'b0, '0);
    add_row(mk_req(ehs_pkg::OP_TICK, 3'd0, 2'b00, 1'b0, 6'h00, 16'd7, 10'h3FF, 10'h3FF),
            1'b0, '0);
    add_row(mk_req(ehs_pkg::OP_TICK, 3'd0, 2'b00, 1'b0, 6'h00, 16'h8000, 10'h3FF, 10'h3FF),
            1'b0, '0);
    add_row(mk_req(ehs_pkg::OP_START, 3'd2, 2'b10, 1'b0, 6'h00, 16'd0, 10'h3FF, 10'h3FF),
            1'b0, '0);
    add_row(mk_req(ehs_pkg::OP_TICK, 3'd0, 2'b00, 1'b1, 6'h00, 16'd0, 10'h3FF, 10'h3FF),
            1'b0, '0);
    add_row(mk_req(ehs_pkg::OP_TICK, 3'd0, 2'b00, 1'b0, 6'h00, 16'd99, 10'h3FF, 10'h3FF),
            1'b0, '0);
    add_row(mk_req(ehs_pkg::OP_TICK, 3'd0, 2'b00, 1'b0, 6'h00, 16'd1, 10'h3FF, 10'h3FF),
            1'b0, '0);
    add_row(mk_req(ehs_pkg::OP_TICK, 3'd0, 2'b00, 1'b0, 6'h00, 16'd0, 10'h3FF, 10'h3FF),
            1'b0, '0);
    add_row(mk_req(ehs_pkg::OP_START, 3'd7, 2'b00, 1'b0, 6'h00, 16'd0, 10'h3FF, 10'h3FF),
            1'b0, '0);

    // Hold reset, then release it
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[i]) send_request(plan[i].req, plan[i].fixed, plan[i].res);
    drain_reports();

    // Random traffic under each register setting
    for (int ph = 0; ph < 7; ph++) begin
      load_setting(ph);
      run_random(175);
      drain_reports();
    end

    if (mismatches == 0 && due_reports.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
